>>> rtl/core/sabl_pkg.sv
// Shared types and constants for the skeleton average branch length block.
// No dependencies.
package sabl_pkg;

   localparam int MAX_VERTICES_DEF = 4096;
   localparam int COORD_BITS_DEF   = 24;
   localparam int TOTAL_W          = 48;
   localparam int END_W            = 12;
   localparam int COUNT_OUT_W      = 13;
   localparam int COUNT_OUT_MAX    = 8191;
   localparam int DEG_W            = 2;

   typedef enum logic [1:0] {
      OP_LOAD   = 2'd0,
      OP_EDGE   = 2'd1,
      OP_FINISH = 2'd2
   } opcode_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_EDGE_B,
      S_EDGE_C,
      S_EDGE_D,
      S_MUL,
      S_ROOT_GO,
      S_ROOT_WAIT,
      S_SCAN,
      S_DIV_GO,
      S_DIV_WAIT,
      S_EMIT
   } state_type;

   function automatic logic [DEG_W-1:0] deg_add(input logic [DEG_W-1:0] d,
                                                input logic [DEG_W-1:0] inc);
      logic [DEG_W:0] s;
      s = {1'b0, d} + {1'b0, inc};
      return (s > (DEG_W+1)'(2)) ? DEG_W'(2) : s[DEG_W-1:0];
   endfunction

endpackage

>>> rtl/core/sabl_ram.sv
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies.
module sabl_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/core/sabl_isqrt.sv
// Bit-serial integer square root, one root bit per cycle, rounded down.
// No dependencies.
module sabl_isqrt #(
   parameter int IN_W = 50
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [IN_W-1:0]     radicand,
   output logic                done,
   output logic [IN_W/2-1:0]   root
);

   localparam int ROOT_W = IN_W / 2;
   localparam int CNT_W  = $clog2(ROOT_W + 1);

   logic [IN_W-1:0]   n_ff;
   logic [ROOT_W:0]   rem_ff;
   logic [ROOT_W-1:0] root_ff;
   logic [CNT_W-1:0]  cnt_ff;
   logic              busy_ff;
   logic              done_ff;

   logic [ROOT_W+2:0] step_r;
   logic [ROOT_W+2:0] step_t;
   logic              step_ge;
   logic [ROOT_W+2:0] step_d;

   always_comb begin
      step_r  = {rem_ff, n_ff[IN_W-1 -: 2]};
      step_t  = {1'b0, root_ff, 2'b01};
      step_ge = step_r >= step_t;
      step_d  = step_r - step_t;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            n_ff    <= radicand;
            rem_ff  <= '0;
            root_ff <= '0;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            n_ff    <= {n_ff[IN_W-3:0], 2'b00};
            rem_ff  <= step_ge ? step_d[ROOT_W:0] : step_r[ROOT_W:0];
            root_ff <= {root_ff[ROOT_W-2:0], step_ge};
            cnt_ff  <= cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(ROOT_W - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done = done_ff;
   assign root = root_ff;

endmodule

>>> rtl/core/sabl_div.sv
// Restoring divider, one quotient bit per cycle, for total / endpoint count.
// Depends on sabl_pkg.
module sabl_div #(
   parameter int DIV_W = 13
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [sabl_pkg::TOTAL_W-1:0] dividend,
   input  logic [DIV_W-1:0]            divisor,
   output logic                        done,
   output logic [sabl_pkg::TOTAL_W-1:0] quotient
);

   localparam int QW    = sabl_pkg::TOTAL_W;
   localparam int CNT_W = $clog2(QW + 1);

   logic [QW-1:0]    quo_ff;
   logic [DIV_W-1:0] rem_ff;
   logic [DIV_W-1:0] den_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic             busy_ff;
   logic             done_ff;

   logic [DIV_W:0] step_r;
   logic           step_ge;
   logic [DIV_W:0] step_d;

   always_comb begin
      step_r  = {rem_ff, quo_ff[QW-1]};
      step_ge = step_r >= {1'b0, den_ff};
      step_d  = step_r - {1'b0, den_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            quo_ff  <= dividend;
            den_ff  <= divisor;
            rem_ff  <= '0;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            quo_ff <= {quo_ff[QW-2:0], step_ge};
            rem_ff <= step_ge ? step_d[DIV_W-1:0] : step_r[DIV_W-1:0];
            cnt_ff <= cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(QW - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

>>> rtl/core/skeleton_average_branch_length.sv
// Top level: command sequencer around the vertex coordinate and degree RAMs.
// Depends on sabl_pkg, sabl_ram, sabl_isqrt, sabl_div.
//
// Loads may arrive back to back. An edge takes the bit-serial square root of the
// squared distance between its end vertices; the coordinate RAM has one read port,
// so the two end vertices are fetched in turn. Finish reads the degree RAM once per
// loaded vertex, then runs a bit-serial divide of the 48-bit total. The degree of
// a vertex is zeroed when it is loaded, so no clearing pass is needed after reset
// or finish. A result waiting on rsp_stall does not block loads or edges; only the
// next finish waits for it.
module skeleton_average_branch_length #(
   parameter int MAX_VERTICES = sabl_pkg::MAX_VERTICES_DEF,
   parameter int COORD_BITS   = sabl_pkg::COORD_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [1:0]                          req_opcode,
   input  logic signed [23:0]                  req_coord_x,
   input  logic signed [23:0]                  req_coord_y,
   input  logic signed [23:0]                  req_coord_z,
   input  logic [sabl_pkg::END_W-1:0]          req_end_a,
   input  logic [sabl_pkg::END_W-1:0]          req_end_b,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [sabl_pkg::TOTAL_W-1:0]        rsp_average_length,
   output logic [sabl_pkg::TOTAL_W-1:0]        rsp_total_length,
   output logic [sabl_pkg::COUNT_OUT_W-1:0]    rsp_endpoint_count,
   output logic                                rsp_no_endpoints,
   output logic                                rsp_range_error
);

   localparam int AW    = $clog2(MAX_VERTICES);
   localparam int VC_W  = $clog2(MAX_VERTICES + 1);
   localparam int CMP_W = (VC_W > sabl_pkg::END_W) ? VC_W : sabl_pkg::END_W;
   localparam int OC_W  = (VC_W > sabl_pkg::COUNT_OUT_W) ? VC_W : sabl_pkg::COUNT_OUT_W;
   localparam int CB    = COORD_BITS;
   localparam int CW    = 3 * CB;
   localparam int SQ_W  = 2 * CB + 2;
   localparam int SUM_W = 2 * CB + 4;
   localparam int RT_W  = SUM_W / 2;
   localparam int TW    = sabl_pkg::TOTAL_W;
   localparam int DW    = sabl_pkg::DEG_W;

   sabl_pkg::state_type state_ff, state_in;

   logic [VC_W-1:0]  vcount_ff, vcount_in;
   logic [TW-1:0]    total_ff, total_in;
   logic             err_ff, err_in;
   logic [AW-1:0]    a_ff, a_in;
   logic [AW-1:0]    b_ff, b_in;
   logic             self_ff, self_in;
   logic [CW-1:0]    ca_ff, ca_in;
   logic [CW-1:0]    cb_ff, cb_in;
   logic [DW-1:0]    da_ff, da_in;
   logic [DW-1:0]    db_ff, db_in;
   logic [1:0]       mulk_ff, mulk_in;
   logic [SQ_W-1:0]  prod_ff, prod_in;
   logic [SUM_W-1:0] sum_ff, sum_in;
   logic [VC_W-1:0]  scan_ff, scan_in;
   logic             pend_ff, pend_in;
   logic [VC_W-1:0]  count_ff, count_in;

   logic             rsp_valid_ff, rsp_valid_in;
   logic [TW-1:0]    rsp_avg_ff, rsp_avg_in;
   logic [TW-1:0]    rsp_tot_ff, rsp_tot_in;
   logic [sabl_pkg::COUNT_OUT_W-1:0] rsp_cnt_ff, rsp_cnt_in;
   logic             rsp_none_ff, rsp_none_in;
   logic             rsp_err_ff, rsp_err_in;

   logic [AW-1:0]    rd_addr;
   logic [CW-1:0]    coord_rd;
   logic [DW-1:0]    deg_rd;
   logic             cw_en;
   logic [CW-1:0]    cw_data;
   logic             dw_en;
   logic [AW-1:0]    dw_addr;
   logic [DW-1:0]    dw_data;

   logic             root_start, root_done;
   logic [RT_W-1:0]  root;
   logic             div_start, div_done;
   logic [TW-1:0]    quotient;

   logic [CMP_W-1:0] end_a_x, end_b_x, vcount_x;
   logic             accept;
   logic signed [CB-1:0] sel_a, sel_b;
   logic signed [CB:0]   diff;
   logic [CB:0]          mag;
   logic [SQ_W-1:0]      sq;
   logic [TW:0]          tot_sum;
   logic [OC_W-1:0]      count_x;

   sabl_ram #(.WIDTH(CW), .DEPTH(MAX_VERTICES)) u_coord_ram (
      .clock   (clock),
      .wr_en   (cw_en),
      .wr_addr (vcount_ff[AW-1:0]),
      .wr_data (cw_data),
      .rd_addr (rd_addr),
      .rd_data (coord_rd)
   );

   sabl_ram #(.WIDTH(DW), .DEPTH(MAX_VERTICES)) u_degree_ram (
      .clock   (clock),
      .wr_en   (dw_en),
      .wr_addr (dw_addr),
      .wr_data (dw_data),
      .rd_addr (rd_addr),
      .rd_data (deg_rd)
   );

   sabl_isqrt #(.IN_W(SUM_W)) u_isqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (root_start),
      .radicand (sum_ff),
      .done     (root_done),
      .root     (root)
   );

   sabl_div #(.DIV_W(VC_W)) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (total_ff),
      .divisor  (count_ff),
      .done     (div_done),
      .quotient (quotient)
   );

   always_comb begin
      end_a_x  = CMP_W'(req_end_a);
      end_b_x  = CMP_W'(req_end_b);
      vcount_x = CMP_W'(vcount_ff);
      accept   = req_valid && !req_stall;
      cw_data  = {req_coord_z[CB-1:0], req_coord_y[CB-1:0], req_coord_x[CB-1:0]};

      case (mulk_ff)
         2'd0:    begin sel_a = ca_ff[0 +: CB];    sel_b = cb_ff[0 +: CB];    end
         2'd1:    begin sel_a = ca_ff[CB +: CB];   sel_b = cb_ff[CB +: CB];   end
         default: begin sel_a = ca_ff[2*CB +: CB]; sel_b = cb_ff[2*CB +: CB]; end
      endcase
      diff    = {sel_a[CB-1], sel_a} - {sel_b[CB-1], sel_b};
      mag     = diff[CB] ? -diff : diff;
      sq      = SQ_W'(mag) * SQ_W'(mag);
      tot_sum = {1'b0, total_ff} + (TW+1)'(root);
      count_x = OC_W'(count_ff);
   end

   always_comb begin
      state_in     = state_ff;
      vcount_in    = vcount_ff;
      total_in     = total_ff;
      err_in       = err_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      self_in      = self_ff;
      ca_in        = ca_ff;
      cb_in        = cb_ff;
      da_in        = da_ff;
      db_in        = db_ff;
      mulk_in      = mulk_ff;
      prod_in      = prod_ff;
      sum_in       = sum_ff;
      scan_in      = scan_ff;
      pend_in      = 1'b0;
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_avg_in   = rsp_avg_ff;
      rsp_tot_in   = rsp_tot_ff;
      rsp_cnt_in   = rsp_cnt_ff;
      rsp_none_in  = rsp_none_ff;
      rsp_err_in   = rsp_err_ff;
      req_stall    = 1'b1;
      rd_addr      = a_ff;
      cw_en        = 1'b0;
      dw_en        = 1'b0;
      dw_addr      = vcount_ff[AW-1:0];
      dw_data      = '0;
      root_start   = 1'b0;
      div_start    = 1'b0;

      unique case (state_ff)
         sabl_pkg::S_IDLE: begin
            req_stall = 1'b0;
            rd_addr   = end_a_x[AW-1:0];
            if (accept) begin
               case (req_opcode)
                  sabl_pkg::OP_LOAD: begin
                     if (vcount_ff == VC_W'(MAX_VERTICES)) begin
                        err_in = 1'b1;
                     end else begin
                        cw_en     = 1'b1;
                        dw_en     = 1'b1;
                        vcount_in = vcount_ff + VC_W'(1);
                     end
                  end
                  sabl_pkg::OP_EDGE: begin
                     if (end_a_x >= vcount_x || end_b_x >= vcount_x) begin
                        err_in = 1'b1;
                     end else begin
                        a_in     = end_a_x[AW-1:0];
                        b_in     = end_b_x[AW-1:0];
                        self_in  = (end_a_x == end_b_x);
                        state_in = sabl_pkg::S_EDGE_B;
                     end
                  end
                  sabl_pkg::OP_FINISH: begin
                     scan_in  = '0;
                     count_in = '0;
                     state_in = sabl_pkg::S_SCAN;
                  end
                  default: ;
               endcase
            end
         end
         sabl_pkg::S_EDGE_B: begin
            rd_addr  = b_ff;
            ca_in    = coord_rd;
            da_in    = deg_rd;
            state_in = sabl_pkg::S_EDGE_C;
         end
         sabl_pkg::S_EDGE_C: begin
            cb_in    = coord_rd;
            db_in    = deg_rd;
            dw_en    = 1'b1;
            dw_addr  = a_ff;
            dw_data  = sabl_pkg::deg_add(da_ff, self_ff ? DW'(2) : DW'(1));
            state_in = sabl_pkg::S_EDGE_D;
         end
         sabl_pkg::S_EDGE_D: begin
            dw_en    = !self_ff;
            dw_addr  = b_ff;
            dw_data  = sabl_pkg::deg_add(db_ff, DW'(1));
            mulk_in  = '0;
            sum_in   = '0;
            state_in = sabl_pkg::S_MUL;
         end
         sabl_pkg::S_MUL: begin
            if (mulk_ff != 2'd3) begin
               prod_in = sq;
            end
            if (mulk_ff != 2'd0) begin
               sum_in = sum_ff + SUM_W'(prod_ff);
            end
            mulk_in = mulk_ff + 2'd1;
            if (mulk_ff == 2'd3) begin
               state_in = sabl_pkg::S_ROOT_GO;
            end
         end
         sabl_pkg::S_ROOT_GO: begin
            root_start = 1'b1;
            state_in   = sabl_pkg::S_ROOT_WAIT;
         end
         sabl_pkg::S_ROOT_WAIT: begin
            if (root_done) begin
               total_in = tot_sum[TW] ? '1 : tot_sum[TW-1:0];
               state_in = sabl_pkg::S_IDLE;
            end
         end
         sabl_pkg::S_SCAN: begin
            rd_addr = scan_ff[AW-1:0];
            if (pend_ff && deg_rd == DW'(1)) begin
               count_in = count_ff + VC_W'(1);
            end
            if (scan_ff != vcount_ff) begin
               scan_in = scan_ff + VC_W'(1);
               pend_in = 1'b1;
            end else if (!pend_ff) begin
               state_in = sabl_pkg::S_DIV_GO;
            end
         end
         sabl_pkg::S_DIV_GO: begin
            div_start = 1'b1;
            state_in  = sabl_pkg::S_DIV_WAIT;
         end
         sabl_pkg::S_DIV_WAIT: begin
            if (div_done) begin
               state_in = sabl_pkg::S_EMIT;
            end
         end
         sabl_pkg::S_EMIT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_none_in  = (count_ff == '0);
               rsp_avg_in   = (count_ff == '0) ? '0 : quotient;
               rsp_tot_in   = total_ff;
               rsp_cnt_in   = (count_x > OC_W'(sabl_pkg::COUNT_OUT_MAX)) ?
                              sabl_pkg::COUNT_OUT_W'(sabl_pkg::COUNT_OUT_MAX) :
                              count_x[sabl_pkg::COUNT_OUT_W-1:0];
               rsp_err_in   = err_ff;
               vcount_in    = '0;
               total_in     = '0;
               err_in       = 1'b0;
               state_in     = sabl_pkg::S_IDLE;
            end
         end
         default: state_in = sabl_pkg::S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= sabl_pkg::S_IDLE;
         vcount_ff    <= '0;
         total_ff     <= '0;
         err_ff       <= 1'b0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         vcount_ff    <= vcount_in;
         total_ff     <= total_in;
         err_ff       <= err_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      a_ff        <= a_in;
      b_ff        <= b_in;
      self_ff     <= self_in;
      ca_ff       <= ca_in;
      cb_ff       <= cb_in;
      da_ff       <= da_in;
      db_ff       <= db_in;
      mulk_ff     <= mulk_in;
      prod_ff     <= prod_in;
      sum_ff      <= sum_in;
      scan_ff     <= scan_in;
      count_ff    <= count_in;
      rsp_avg_ff  <= rsp_avg_in;
      rsp_tot_ff  <= rsp_tot_in;
      rsp_cnt_ff  <= rsp_cnt_in;
      rsp_none_ff <= rsp_none_in;
      rsp_err_ff  <= rsp_err_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_average_length = rsp_avg_ff;
   assign rsp_total_length   = rsp_tot_ff;
   assign rsp_endpoint_count = rsp_cnt_ff;
   assign rsp_no_endpoints   = rsp_none_ff;
   assign rsp_range_error    = rsp_err_ff;

endmodule
